>>> hw/rtl/sdi_pkg.sv
package sdi_pkg;

  // sequence phases
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_WAKE = 4'd1,
    PH_P0   = 4'd2,
    PH_F0   = 4'd3,
    PH_P8   = 4'd4,
    PH_F8   = 4'd5,
    PH_R7   = 4'd6,
    PH_P55  = 4'd7,
    PH_F55  = 4'd8,
    PH_P41  = 4'd9,
    PH_F41  = 4'd10,
    PH_P58  = 4'd11,
    PH_F58  = 4'd12,
    PH_OCR  = 4'd13,
    PH_DONE = 4'd14
  } phase_e;

  // operation codes
  localparam logic OpStart    = 1'b0;
  localparam logic OpExchange = 1'b1;

  localparam logic [5:0] WakeBytes  = 6'd10;
  localparam logic [5:0] FrameBytes = 6'd10;

  localparam logic [3:0]  FrameTriesReset = 4'd5;
  localparam logic [7:0]  IdleByte        = 8'hFF;
  localparam logic [7:0]  R1Idle          = 8'h01;
  localparam logic [7:0]  CheckPattern    = 8'hAA;
  localparam logic [31:0] ArgCmd8         = 32'h0000_01AA;
  localparam logic [31:0] ArgAcmd41       = 32'h4000_0000;

  localparam logic [5:0] Cmd0  = 6'd0;
  localparam logic [5:0] Cmd8  = 6'd8;
  localparam logic [5:0] Cmd55 = 6'd55;
  localparam logic [5:0] Cmd41 = 6'd41;
  localparam logic [5:0] Cmd58 = 6'd58;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       select_active;
    logic       finished;
    logic       card_found;
  } out_item_t;

  typedef struct packed {
    phase_e     phase;
    logic [4:0] byte_index;
    logic [3:0] try_count;
    logic [6:0] crc_acc;
    logic       reply_seen;
    logic [7:0] reply_value;
    logic       found_flag;
  } seq_state_t;

  // write into the long reply buffer
  typedef struct packed {
    logic       we;
    logic [1:0] idx;
    logic [7:0] data;
  } lr_write_t;

  // crc7 (x^7 + x^3 + 1) over one byte, msb first
  function automatic logic [6:0] crc7_byte(logic [6:0] c, logic [7:0] b);
    logic [6:0] r;
    logic       fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[6] ^ b[i];
      r = {r[5:0], 1'b0};
      if (fb) begin
        r = r ^ 7'h09;
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/sd_spi_init_sequencer_top.sv
// sd card spi-mode power-up sequencer
//
// input channel (in_valid_i / in_stall_o / in_data_i): one item per event,
//   operation start begins the sequence, operation exchange reports one
//   finished spi byte with the byte the card sent back
// output channel (out_valid_o / out_stall_i / out_data_o): one item per
//   input item with the next byte to shift out, chip select and status
// config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): frame_tries,
//   always ready, write it only while no item is in flight
//
// from acceptance to the result item an item passes an input register,
// then the whole state update and crc7 step into the result register.
// one item per cycle is sustained while the receiver does not stall; the
// state update and the byte-wide crc7 lie between those two registers.
// a stalled result holds; the input register still takes an item while
// the result waits, and in_stall_o rises only when both are full.
// reset: phase idle, frame_tries 5, both registers empty.
module sd_spi_init_sequencer_top import sdi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  // input register
  logic       in_valid_q;
  in_item_t   in_item_q;
  // sequence state
  seq_state_t st_q, st_d;
  logic [3:0] frame_tries_q;
  logic [7:0] long_reply_q [4];
  lr_write_t  lr_wr;
  // result register
  logic       out_valid_q;
  out_item_t  out_item_q, out_item_d;

  logic out_free;
  logic fire;

  // result register can take a new item this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign cfg_ready_o = 1'b1;

  sdi_step u_step (
    .st_i          (st_q),
    .item_i        (in_item_q),
    .frame_tries_i (frame_tries_q),
    .lr0_i         (long_reply_q[0]),
    .lr2_i         (long_reply_q[2]),
    .st_o          (st_d),
    .lr_o          (lr_wr),
    .out_o         (out_item_d)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      frame_tries_q <= FrameTriesReset;
      st_q          <= '{phase: PH_IDLE, byte_index: '0, try_count: '0, crc_acc: '0,
                         reply_seen: 1'b0, reply_value: IdleByte, found_flag: 1'b0};
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        frame_tries_q <= cfg_data_i;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
    if (fire) begin
      out_item_q <= out_item_d;
    end
    // r7 / ocr bytes, each written before it is read
    if (fire && lr_wr.we) begin
      long_reply_q[lr_wr.idx] <= lr_wr.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

>>> hw/rtl/sdi_step.sv
module sdi_step import sdi_pkg::*; (
  input  seq_state_t st_i,
  input  in_item_t   item_i,
  input  logic [3:0] frame_tries_i,
  input  logic [7:0] lr0_i,
  input  logic [7:0] lr2_i,
  output seq_state_t st_o,
  output lr_write_t  lr_o,
  output out_item_t  out_o
);

  seq_state_t nx;
  seq_state_t fin;
  logic       seen_n;
  logic [7:0] value_n;
  logic [3:0] try_n;
  logic       running;
  logic       in_frame;
  logic [5:0] cmd;
  logic [31:0] arg;
  logic [7:0] tx;

  always_comb begin
    nx     = st_i;
    lr_o   = '{we: 1'b0, idx: st_i.byte_index[1:0], data: item_i.rx_byte};
    seen_n  = st_i.reply_seen;
    value_n = st_i.reply_value;
    try_n   = st_i.try_count + 4'd1;

    if (item_i.operation == OpStart) begin
      nx.phase       = PH_WAKE;
      nx.byte_index  = '0;
      nx.try_count   = '0;
      nx.crc_acc     = '0;
      nx.reply_seen  = 1'b0;
      nx.reply_value = IdleByte;
      nx.found_flag  = 1'b0;
    end else begin
      case (st_i.phase)
        PH_WAKE: begin
          if ({1'b0, st_i.byte_index} + 6'd1 < WakeBytes) begin
            nx.byte_index = st_i.byte_index + 5'd1;
          end else begin
            nx.phase      = PH_P0;
            nx.byte_index = '0;
            nx.try_count  = '0;
          end
        end
        PH_P0, PH_P8, PH_P55, PH_P41, PH_P58: begin
          if (item_i.rx_byte == IdleByte) begin
            nx.phase       = phase_e'(st_i.phase + 4'd1);
            nx.byte_index  = '0;
            nx.crc_acc     = '0;
            nx.reply_seen  = 1'b0;
            nx.reply_value = IdleByte;
          end
        end
        PH_F0, PH_F8, PH_F55, PH_F41, PH_F58: begin
          // r1 is the first byte from position 6 on with bit 7 clear
          if (st_i.byte_index >= 5'd6 && !st_i.reply_seen && !item_i.rx_byte[7]) begin
            seen_n  = 1'b1;
            value_n = item_i.rx_byte;
          end
          nx.reply_seen  = seen_n;
          nx.reply_value = value_n;
          if ({1'b0, st_i.byte_index} + 6'd1 < FrameBytes) begin
            nx.byte_index = st_i.byte_index + 5'd1;
          end else if (!seen_n) begin
            nx.try_count = try_n;
            if (try_n < frame_tries_i) begin
              nx.byte_index  = '0;
              nx.crc_acc     = '0;
              nx.reply_seen  = 1'b0;
              nx.reply_value = IdleByte;
            end else begin
              nx.phase      = PH_DONE;
              nx.byte_index = '0;
              nx.found_flag = 1'b0;
            end
          end else if (value_n != R1Idle) begin
            nx.phase      = PH_DONE;
            nx.byte_index = '0;
            nx.found_flag = 1'b0;
          end else begin
            nx.byte_index = '0;
            case (st_i.phase)
              PH_F0: begin
                nx.phase     = PH_P8;
                nx.try_count = '0;
              end
              PH_F8: begin
                nx.phase = PH_R7;
              end
              PH_F55: begin
                nx.phase     = PH_P41;
                nx.try_count = '0;
              end
              PH_F41: begin
                nx.phase     = PH_P58;
                nx.try_count = '0;
              end
              default: begin
                nx.phase = PH_OCR;
              end
            endcase
          end
        end
        PH_R7, PH_OCR: begin
          lr_o.we = 1'b1;
          if (st_i.byte_index < 5'd3) begin
            nx.byte_index = st_i.byte_index + 5'd1;
          end else if (st_i.phase == PH_R7) begin
            nx.byte_index = '0;
            if (lr2_i[0] && item_i.rx_byte == CheckPattern) begin
              nx.phase     = PH_P55;
              nx.try_count = '0;
            end else begin
              nx.phase      = PH_DONE;
              nx.found_flag = 1'b0;
            end
          end else begin
            nx.phase      = PH_DONE;
            nx.byte_index = '0;
            nx.found_flag = (lr0_i[7:6] == 2'b11);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // byte to send from the updated state; crc takes in header bytes
  always_comb begin
    fin      = nx;
    running  = (nx.phase >= PH_WAKE) && (nx.phase <= PH_OCR);
    in_frame = (nx.phase == PH_F0) || (nx.phase == PH_F8) || (nx.phase == PH_F55) ||
               (nx.phase == PH_F41) || (nx.phase == PH_F58);
    case (nx.phase)
      PH_F8:   cmd = Cmd8;
      PH_F55:  cmd = Cmd55;
      PH_F41:  cmd = Cmd41;
      PH_F58:  cmd = Cmd58;
      default: cmd = Cmd0;
    endcase
    case (nx.phase)
      PH_F8:   arg = ArgCmd8;
      PH_F41:  arg = ArgAcmd41;
      default: arg = '0;
    endcase
    tx = IdleByte;
    if (running && in_frame) begin
      case (nx.byte_index)
        5'd0:    tx = {2'b01, cmd};
        5'd1:    tx = arg[31:24];
        5'd2:    tx = arg[23:16];
        5'd3:    tx = arg[15:8];
        5'd4:    tx = arg[7:0];
        5'd5:    tx = {nx.crc_acc, 1'b1};
        default: tx = IdleByte;
      endcase
      if (nx.byte_index <= 5'd4) begin
        fin.crc_acc = crc7_byte(nx.crc_acc, tx);
      end
    end
    st_o = fin;
    out_o.tx_byte       = tx;
    out_o.tx_valid      = running;
    out_o.select_active = running;
    out_o.finished      = (nx.phase == PH_DONE);
    out_o.card_found    = (nx.phase == PH_DONE) && nx.found_flag;
  end

endmodule

>>> tb/sd_spi_init_sequencer_top_tb.sv
`timescale 1ns / 100ps

module sd_spi_init_sequencer_top_tb;
  import sdi_pkg::*;

  localparam int ResultLatency  = 2;     // input register, then result register
  localparam int WatchdogLimit  = 2000;  // cycles with no handshake at all
  localparam int LongHoldCycles = 80;    // receiver hold-off under pressure
  localparam int ItemsPerPhase  = 270;   // counted items per retry setting

  // status items simple enough to type in
  localparam out_item_t QuietStatus = '{IdleByte, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam out_item_t WakeFill    = '{IdleByte, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam out_item_t Cmd0Header  = '{{2'b01, Cmd0}, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam out_item_t ZeroArgByte = '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0};

  typedef struct packed {
    in_item_t  stim;
    logic      typed;  // compare against want instead of the predictor
    out_item_t want;
  } directed_row_t;

  localparam int DirectedRows = 22;

  // directed part: idle exchanges, wake bytes with extreme rx values,
  // a busy card while polling, the cmd0 header and argument, then a restart
  localparam directed_row_t DirectedTable [DirectedRows] = '{
    '{'{OpExchange, 8'h00}, 1'b1, QuietStatus},   // exchange while idle
    '{'{OpExchange, 8'hFF}, 1'b1, QuietStatus},
    '{'{OpStart,    8'h00}, 1'b1, WakeFill},
    '{'{OpExchange, 8'h00}, 1'b1, WakeFill},      // ten wake bytes
    '{'{OpExchange, 8'hFF}, 1'b1, WakeFill},
    '{'{OpExchange, 8'h55}, 1'b1, WakeFill},
    '{'{OpExchange, 8'hAA}, 1'b1, WakeFill},
    '{'{OpExchange, 8'h80}, 1'b1, WakeFill},
    '{'{OpExchange, 8'h7F}, 1'b1, WakeFill},
    '{'{OpExchange, 8'h01}, 1'b1, WakeFill},
    '{'{OpExchange, 8'hFE}, 1'b1, WakeFill},
    '{'{OpExchange, 8'h00}, 1'b1, WakeFill},
    '{'{OpExchange, 8'hFF}, 1'b1, WakeFill},      // last wake byte, polling next
    '{'{OpExchange, 8'h00}, 1'b1, WakeFill},      // card busy
    '{'{OpExchange, 8'hFE}, 1'b1, WakeFill},
    '{'{OpExchange, 8'hFF}, 1'b1, Cmd0Header},    // card ready, cmd0 goes out
    '{'{OpExchange, 8'hFF}, 1'b1, ZeroArgByte},
    '{'{OpExchange, 8'h00}, 1'b1, ZeroArgByte},
    '{'{OpExchange, 8'h80}, 1'b1, ZeroArgByte},
    '{'{OpExchange, 8'h7F}, 1'b1, ZeroArgByte},
    '{'{OpExchange, 8'h00}, 1'b0, QuietStatus},   // crc byte from the predictor
    '{'{OpStart,    8'hFF}, 1'b1, WakeFill}       // start while running
  };

  // dut ports, all known from time zero
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i  = '0;

  // predicted card sequence state
  phase_e     seq_phase   = PH_IDLE;
  logic [4:0] seq_pos     = '0;
  logic [3:0] seq_tries   = '0;
  logic [6:0] seq_crc     = '0;
  logic       seq_got_r1  = 1'b0;
  logic [7:0] seq_r1      = IdleByte;
  logic [7:0] seq_long [4] = '{default: 8'h00};
  logic       seq_ok      = 1'b0;
  logic [3:0] tries_cfg   = FrameTriesReset;

  out_item_t expected_q [$];

  // run control and bookkeeping
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_long      = 1'b0;
  int   errors         = 0;
  int   n_accepted     = 0;
  int   n_checked      = 0;
  int   n_starts       = 0;
  int   n_found        = 0;
  int   n_lost         = 0;
  int   quiet_cycles   = 0;

  sd_spi_init_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic is_frame_phase(phase_e p);
    return p inside {PH_F0, PH_F8, PH_F55, PH_F41, PH_F58};
  endfunction

  // advances the predicted sequence by one item and returns the status item
  function automatic out_item_t step_card_sequence(in_item_t it);
    out_item_t   res;
    logic [31:0] arg;
    logic [5:0]  cmd;
    logic [7:0]  b;
    logic        fb;
    res = QuietStatus;
    if (it.operation == OpStart) begin
      // start, also mid-sequence: back to the wake bytes
      seq_phase  = PH_WAKE;
      seq_pos    = '0;
      seq_tries  = '0;
      seq_crc    = '0;
      seq_got_r1 = 1'b0;
      seq_r1     = IdleByte;
      seq_ok     = 1'b0;
    end else begin
      case (seq_phase)
        PH_WAKE: begin
          if (int'(seq_pos) + 1 < int'(WakeBytes)) begin
            seq_pos = seq_pos + 5'd1;
          end else begin
            seq_phase = PH_P0;
            seq_pos   = '0;
            seq_tries = '0;
          end
        end
        PH_P0, PH_P8, PH_P55, PH_P41, PH_P58: begin
          // busy card keeps us polling
          if (it.rx_byte == IdleByte) begin
            seq_phase  = phase_e'(seq_phase + 4'd1);
            seq_pos    = '0;
            seq_crc    = '0;
            seq_got_r1 = 1'b0;
            seq_r1     = IdleByte;
          end
        end
        PH_F0, PH_F8, PH_F55, PH_F41, PH_F58: begin
          if (seq_pos >= 5'd6 && !seq_got_r1 && !it.rx_byte[7]) begin
            seq_got_r1 = 1'b1;
            seq_r1     = it.rx_byte;
          end
          if (int'(seq_pos) + 1 < int'(FrameBytes)) begin
            seq_pos = seq_pos + 5'd1;
          end else if (!seq_got_r1) begin
            // no r1 in the frame: resend or give up
            seq_tries = seq_tries + 4'd1;
            seq_pos   = '0;
            if (seq_tries < tries_cfg) begin
              seq_crc    = '0;
              seq_got_r1 = 1'b0;
              seq_r1     = IdleByte;
            end else begin
              seq_phase = PH_DONE;
              seq_ok    = 1'b0;
            end
          end else begin
            seq_pos = '0;
            if (seq_r1 != R1Idle) begin
              seq_phase = PH_DONE;
              seq_ok    = 1'b0;
            end else begin
              case (seq_phase)
                PH_F0: begin
                  seq_phase = PH_P8;
                  seq_tries = '0;
                end
                PH_F8:  seq_phase = PH_R7;
                PH_F55: begin
                  seq_phase = PH_P41;
                  seq_tries = '0;
                end
                PH_F41: begin
                  seq_phase = PH_P58;
                  seq_tries = '0;
                end
                default: seq_phase = PH_OCR;
              endcase
            end
          end
        end
        PH_R7, PH_OCR: begin
          seq_long[seq_pos[1:0]] = it.rx_byte;
          if (seq_pos < 5'd3) begin
            seq_pos = seq_pos + 5'd1;
          end else begin
            seq_pos = '0;
            if (seq_phase == PH_R7) begin
              if (seq_long[2][0] && seq_long[3] == CheckPattern) begin
                seq_phase = PH_P55;
                seq_tries = '0;
              end else begin
                seq_phase = PH_DONE;
                seq_ok    = 1'b0;
              end
            end else begin
              seq_phase = PH_DONE;
              seq_ok    = &seq_long[0][7:6];
            end
          end
        end
        default: ;  // idle or done: exchange ignored
      endcase
    end

    if (seq_phase >= PH_WAKE && seq_phase <= PH_OCR) begin
      res.tx_valid      = 1'b1;
      res.select_active = 1'b1;
      if (is_frame_phase(seq_phase)) begin
        case (seq_phase)
          PH_F8: begin
            cmd = Cmd8;
            arg = ArgCmd8;
          end
          PH_F55: begin
            cmd = Cmd55;
            arg = '0;
          end
          PH_F41: begin
            cmd = Cmd41;
            arg = ArgAcmd41;
          end
          PH_F58: begin
            cmd = Cmd58;
            arg = '0;
          end
          default: begin
            cmd = Cmd0;
            arg = '0;
          end
        endcase
        if (seq_pos == 5'd0) b = {2'b01, cmd};
        else if (seq_pos <= 5'd4) b = 8'(arg >> (8 * (4 - int'(seq_pos))));
        else if (seq_pos == 5'd5) b = {seq_crc, 1'b1};
        else b = IdleByte;
        res.tx_byte = b;
        // crc7 over the header bytes as they leave, msb first
        if (seq_pos <= 5'd4) begin
          for (int n = 0; n < 8; n++) begin
            fb      = seq_crc[6] ^ b[7 - n];
            seq_crc = {seq_crc[5:0], 1'b0} ^ {3'b000, fb, 2'b00, fb};
          end
        end
      end
    end
    res.finished   = (seq_phase == PH_DONE);
    res.card_found = res.finished && seq_ok;
    return res;
  endfunction

  // offers one item, starting and ending at a falling edge
  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    out_item_t pred;
    logic      was_done;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    was_done = (seq_phase == PH_DONE);
    pred = step_card_sequence(it);
    expected_q.push_back(typed ? want : pred);
    n_accepted++;
    if (it.operation == OpStart) n_starts++;
    if (!was_done && seq_phase == PH_DONE) begin
      if (seq_ok) n_found++;
      else n_lost++;
    end
    @(negedge clk_i);
  endtask

  // sender stops until every expected item is back, then lets the pipe settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (ResultLatency + 2) @(negedge clk_i);
  endtask

  // one retry setting with one idling profile; the card mostly answers
  // the way a healthy card would, with some noise and broken replies
  task automatic run_phase(logic [3:0] tries, int idle_pct, int stall_pct,
                           logic pressure);
    in_item_t it;
    int       counted;
    int       roll;
    logic     ignored;
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= tries;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tries_cfg = tries;
    @(negedge clk_i);
    cfg_valid_i    <= 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    counted = 0;
    while (counted < ItemsPerPhase) begin
      // receiver holds off while we keep offering items
      if (pressure && counted == 90) hold_long = 1'b1;
      // sender waits for every result
      if (pressure && counted == 180) drain_results();

      it.operation = OpExchange;
      it.rx_byte   = 8'($urandom);
      roll = $urandom_range(999);
      if (seq_phase == PH_IDLE || seq_phase == PH_DONE) begin
        if (roll < 700) it.operation = OpStart;
      end else if (roll < 8) begin
        it.operation = OpStart;
      end else if (roll >= 60) begin
        if (is_frame_phase(seq_phase)) begin
          // r1 window: good reply, bad reply or a busy byte
          if (seq_pos >= 5'd6 && !seq_got_r1) begin
            if ($urandom_range(99) < 45)
              it.rx_byte = ($urandom_range(99) < 93) ? R1Idle : {1'b0, 7'($urandom)};
            else
              it.rx_byte[7] = 1'b1;
          end
        end else begin
          case (seq_phase)
            PH_P0, PH_P8, PH_P55, PH_P41, PH_P58: begin
              if ($urandom_range(99) < 75) it.rx_byte = IdleByte;
            end
            PH_R7: begin
              if (seq_pos == 5'd2 && $urandom_range(99) < 95) it.rx_byte[0] = 1'b1;
              if (seq_pos == 5'd3 && $urandom_range(99) < 95) it.rx_byte = CheckPattern;
            end
            PH_OCR: begin
              if (seq_pos == 5'd0 && $urandom_range(99) < 90) it.rx_byte[7:6] = 2'b11;
            end
            default: ;
          endcase
        end
      end
      ignored = (it.operation == OpExchange) &&
                (seq_phase == PH_IDLE || seq_phase == PH_DONE);
      send_item(it, 1'b0, QuietStatus);
      if (!ignored) counted++;
    end
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(negedge clk_i);
        hold_long = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected: %p", out_data_o);
        errors++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (out_data_o.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", want.tx_byte, out_data_o.tx_byte);
          errors++;
        end
        if (out_data_o.tx_valid !== want.tx_valid) begin
          $error("tx_valid: expected %0b, got %0b", want.tx_valid, out_data_o.tx_valid);
          errors++;
        end
        if (out_data_o.select_active !== want.select_active) begin
          $error("select_active: expected %0b, got %0b",
                 want.select_active, out_data_o.select_active);
          errors++;
        end
        if (out_data_o.finished !== want.finished) begin
          $error("finished: expected %0b, got %0b", want.finished, out_data_o.finished);
          errors++;
        end
        if (out_data_o.card_found !== want.card_found) begin
          $error("card_found: expected %0b, got %0b", want.card_found, out_data_o.card_found);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_q.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DirectedRows; r++) begin
      send_item(DirectedTable[r].stim, DirectedTable[r].typed, DirectedTable[r].want);
    end

    // retry budget extremes and values in between, under several idling profiles
    run_phase(4'd1,  0,  0,  1'b1);
    run_phase(4'd15, 57, 0,  1'b0);
    run_phase(4'd0,  0,  57, 1'b0);
    run_phase(4'd3,  21, 21, 1'b0);
    run_phase(4'd2,  0,  0,  1'b1);
    run_phase(4'd5,  21, 21, 1'b0);

    drain_results();
    if (expected_q.size() != 0) begin
      $error("%0d expected result items never arrived", expected_q.size());
      errors++;
    end
    $display("run covered %0d items, %0d sequence starts, %0d cards found, %0d not found",
             n_accepted, n_starts, n_found, n_lost);
    $display("%0d result items checked over retry budgets 0 to 15 with gaps and stalls",
             n_checked);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
